>>> hdl/lpp_pkg.sv
// Shared constants and types for the LiDAR pinhole projection unit.
package lpp_pkg;

  localparam int COEF_BITS     = 32;
  localparam int NUM_ROWS      = 3;
  localparam int NUM_COLS      = 4;
  localparam int NUM_COEFS     = NUM_ROWS * NUM_COLS;
  localparam int SIZE_BITS     = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 64;

  localparam logic [CFG_IDX_BITS-1:0] REG_ROW0_XY    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW0_ZT    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW1_XY    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW1_ZT    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW2_XY    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW2_ZT    = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_SIZE = 3'd6;

  typedef struct packed {
    logic neg_u;
    logic ovf_u;
    logic neg_v;
    logic ovf_v;
    logic depth_inv;
  } lpp_flags_t;

endpackage

>>> hdl/lpp_ifs.sv
// Channel interfaces: point requests, pixel results and register writes.
interface lpp_point_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface lpp_pixel_if #(parameter int PIXEL_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [PIXEL_BITS-1:0] pixel_u;
  logic signed [PIXEL_BITS-1:0] pixel_v;
  logic                         in_image;
  logic                         depth_invalid;
  modport source (output valid, pixel_u, pixel_v, in_image, depth_invalid, input ready);
  modport sink (input valid, pixel_u, pixel_v, in_image, depth_invalid, output ready);
endinterface

interface lpp_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [lpp_pkg::CFG_IDX_BITS-1:0]   index;
  logic [lpp_pkg::CFG_DATA_BITS-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/lpp_mac.sv
// Matrix front end: products, row sums, then sign, magnitude and overflow prep.
module lpp_mac #(
  parameter int CB = 24,
  parameter int QB = 17,
  parameter int SW = 58
) (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  logic                                                   valid_i,
  output logic                                                   ready_o,
  input  logic signed [CB-1:0]                                   x_i,
  input  logic signed [CB-1:0]                                   y_i,
  input  logic signed [CB-1:0]                                   z_i,
  input  logic [lpp_pkg::NUM_COEFS-1:0][lpp_pkg::COEF_BITS-1:0]  coefs_i,
  output logic                                                   valid_o,
  input  logic                                                   ready_i,
  output logic [SW-1:0]                                          rem_u_o,
  output logic [SW-1:0]                                          rem_v_o,
  output logic [SW-1:0]                                          w_o,
  output lpp_pkg::lpp_flags_t                                    flags_o
);
  import lpp_pkg::*;

  localparam int PW = COEF_BITS + CB;

  logic                       v1_q, v2_q, v3_q;
  logic                       en1, en2, en3;
  logic signed [PW-1:0]       prod_q [NUM_ROWS][NUM_ROWS];
  logic signed [PW-1:0]       prod_d [NUM_ROWS][NUM_ROWS];
  logic signed [COEF_BITS-1:0] off_q [NUM_ROWS];
  logic signed [SW-1:0]       sum_q [NUM_ROWS];
  logic signed [SW-1:0]       sum_d [NUM_ROWS];
  logic [SW-1:0]              mag_u, mag_v, w_d;
  logic                       neg_u, neg_v;
  logic [SW+QB-1:0]           lim;
  lpp_flags_t                 flags_d;
  logic [SW-1:0]              rem_u_q, rem_v_q, w_q;
  lpp_flags_t                 flags_q;

  assign en3     = !v3_q || ready_i;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      prod_d[r][0] = PW'($signed(coefs_i[r*NUM_COLS+0]) * x_i);
      prod_d[r][1] = PW'($signed(coefs_i[r*NUM_COLS+1]) * y_i);
      prod_d[r][2] = PW'($signed(coefs_i[r*NUM_COLS+2]) * z_i);
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      sum_d[r] = SW'(prod_q[r][0]) + SW'(prod_q[r][1]) + SW'(prod_q[r][2]) + SW'(off_q[r]);
    end
  end

  always_comb begin
    neg_u     = sum_q[0][SW-1];
    neg_v     = sum_q[1][SW-1];
    mag_u     = neg_u ? SW'(-sum_q[0]) : sum_q[0];
    mag_v     = neg_v ? SW'(-sum_q[1]) : sum_q[1];
    w_d       = sum_q[2];
    lim       = {w_d, {QB{1'b0}}};
    flags_d.neg_u     = neg_u;
    flags_d.neg_v     = neg_v;
    flags_d.ovf_u     = {{QB{1'b0}}, mag_u} >= lim;
    flags_d.ovf_v     = {{QB{1'b0}}, mag_v} >= lim;
    flags_d.depth_inv = w_d[SW-1] || (w_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      prod_q <= prod_d;
      for (int r = 0; r < NUM_ROWS; r++) begin
        off_q[r] <= $signed(coefs_i[r*NUM_COLS+3]);
      end
    end
    if (en2 && v1_q) sum_q <= sum_d;
    if (en3 && v2_q) begin
      rem_u_q <= mag_u;
      rem_v_q <= mag_v;
      w_q     <= w_d;
      flags_q <= flags_d;
    end
  end

  assign valid_o = v3_q;
  assign rem_u_o = rem_u_q;
  assign rem_v_o = rem_v_q;
  assign w_o     = w_q;
  assign flags_o = flags_q;

endmodule

>>> hdl/lpp_div_cell.sv
// One restoring-division cell: resolves one quotient bit for both u and v lanes.
module lpp_div_cell #(
  parameter int SW  = 58,
  parameter int QB  = 17,
  parameter int BIT = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [SW-1:0]       rem_u_i,
  input  logic [SW-1:0]       rem_v_i,
  input  logic [SW-1:0]       w_i,
  input  logic [QB-1:0]       q_u_i,
  input  logic [QB-1:0]       q_v_i,
  input  lpp_pkg::lpp_flags_t flags_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [SW-1:0]       rem_u_o,
  output logic [SW-1:0]       rem_v_o,
  output logic [SW-1:0]       w_o,
  output logic [QB-1:0]       q_u_o,
  output logic [QB-1:0]       q_v_o,
  output lpp_pkg::lpp_flags_t flags_o
);
  import lpp_pkg::*;

  logic             valid_q, en;
  logic [SW+QB-1:0] trial;
  logic             ge_u, ge_v;
  logic [SW-1:0]    rem_u_q, rem_v_q, w_q;
  logic [QB-1:0]    q_u_q, q_v_q;
  lpp_flags_t       flags_q;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;
  assign trial   = {{QB{1'b0}}, w_i} << BIT;
  assign ge_u    = {{QB{1'b0}}, rem_u_i} >= trial;
  assign ge_v    = {{QB{1'b0}}, rem_v_i} >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      rem_u_q <= ge_u ? rem_u_i - trial[SW-1:0] : rem_u_i;
      rem_v_q <= ge_v ? rem_v_i - trial[SW-1:0] : rem_v_i;
      q_u_q   <= {q_u_i[QB-2:0], ge_u};
      q_v_q   <= {q_v_i[QB-2:0], ge_v};
      w_q     <= w_i;
      flags_q <= flags_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_u_o = rem_u_q;
  assign rem_v_o = rem_v_q;
  assign w_o     = w_q;
  assign q_u_o   = q_u_q;
  assign q_v_o   = q_v_q;
  assign flags_o = flags_q;

endmodule

>>> hdl/lpp_out.sv
// Result stage: sign restore, saturation, image bounds and depth flag.
module lpp_out #(
  parameter int QB = 17,
  parameter int PB = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic [QB-1:0]                      q_u_i,
  input  logic [QB-1:0]                      q_v_i,
  input  lpp_pkg::lpp_flags_t                flags_i,
  input  logic [lpp_pkg::SIZE_BITS-1:0]      width_i,
  input  logic [lpp_pkg::SIZE_BITS-1:0]      height_i,
  lpp_pixel_if.source                        pixel_o
);
  import lpp_pkg::*;

  localparam logic [QB-1:0] HALF = QB'(1) << (PB - 1);

  logic                 valid_q, en;
  logic signed [PB-1:0] u_d, v_d, u_q, v_q;
  logic                 in_d, in_q, dinv_q;

  function automatic logic signed [PB-1:0] sat(input logic [QB-1:0] q, input logic neg,
                                               input logic ovf);
    logic [QB-1:0] r;
    if (neg) begin
      r = (ovf || q > HALF) ? HALF : q;
      return PB'(-r);
    end
    r = (ovf || q > HALF - QB'(1)) ? HALF - QB'(1) : q;
    return PB'(r);
  endfunction

  always_comb begin
    if (flags_i.depth_inv) begin
      u_d  = '0;
      v_d  = '0;
      in_d = 1'b0;
    end else begin
      u_d  = sat(q_u_i, flags_i.neg_u, flags_i.ovf_u);
      v_d  = sat(q_v_i, flags_i.neg_v, flags_i.ovf_v);
      in_d = !flags_i.neg_u && !flags_i.ovf_u && (q_u_i < QB'(width_i)) &&
             !flags_i.neg_v && !flags_i.ovf_v && (q_v_i < QB'(height_i));
    end
  end

  assign en      = !valid_q || pixel_o.ready;
  assign ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      u_q    <= u_d;
      v_q    <= v_d;
      in_q   <= in_d;
      dinv_q <= flags_i.depth_inv;
    end
  end

  assign pixel_o.valid         = valid_q;
  assign pixel_o.pixel_u       = u_q;
  assign pixel_o.pixel_v       = v_q;
  assign pixel_o.in_image      = in_q;
  assign pixel_o.depth_invalid = dinv_q;

endmodule

>>> hdl/lidar_point_pinhole_projection_unit.sv
// Top level of the LiDAR point pinhole projection unit.
// A point request passes the matrix front end, the division cell row and the result stage in that order;
// QB = max(PIXEL_BITS, 16) + 1 is the length of the division cell row.
// Throughput: one point per cycle while pixel_out is ready; each cell of the row resolves one quotient bit.
// Reset: clears all valid flags and the projection and image size registers to zero.
module lidar_point_pinhole_projection_unit #(
  parameter int COORD_BITS = 24,
  parameter int PIXEL_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lpp_point_if.sink   point_in,
  lpp_pixel_if.source pixel_out,
  lpp_cfg_if.sink     cfg
);
  import lpp_pkg::*;

  localparam int QB = ((PIXEL_BITS > SIZE_BITS) ? PIXEL_BITS : SIZE_BITS) + 1;
  localparam int SW = COEF_BITS + COORD_BITS + 2;

  logic [NUM_COEFS-1:0][COEF_BITS-1:0] coefs_q;
  logic [SIZE_BITS-1:0]                width_q, height_q;

  logic             c_valid [QB+1];
  logic             c_ready [QB+1];
  logic [SW-1:0]    c_rem_u [QB+1];
  logic [SW-1:0]    c_rem_v [QB+1];
  logic [SW-1:0]    c_w     [QB+1];
  logic [QB-1:0]    c_q_u   [QB+1];
  logic [QB-1:0]    c_q_v   [QB+1];
  lpp_flags_t       c_flags [QB+1];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coefs_q  <= '0;
      width_q  <= '0;
      height_q <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ROW0_XY:    coefs_q[1:0]   <= cfg.data;
        REG_ROW0_ZT:    coefs_q[3:2]   <= cfg.data;
        REG_ROW1_XY:    coefs_q[5:4]   <= cfg.data;
        REG_ROW1_ZT:    coefs_q[7:6]   <= cfg.data;
        REG_ROW2_XY:    coefs_q[9:8]   <= cfg.data;
        REG_ROW2_ZT:    coefs_q[11:10] <= cfg.data;
        REG_IMAGE_SIZE: begin
          width_q  <= cfg.data[SIZE_BITS-1:0];
          height_q <= cfg.data[2*SIZE_BITS-1:SIZE_BITS];
        end
        default: ;
      endcase
    end
  end

  lpp_mac #(.CB(COORD_BITS), .QB(QB), .SW(SW)) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (point_in.valid),
    .ready_o (point_in.ready),
    .x_i     (point_in.point_x),
    .y_i     (point_in.point_y),
    .z_i     (point_in.point_z),
    .coefs_i (coefs_q),
    .valid_o (c_valid[0]),
    .ready_i (c_ready[0]),
    .rem_u_o (c_rem_u[0]),
    .rem_v_o (c_rem_v[0]),
    .w_o     (c_w[0]),
    .flags_o (c_flags[0])
  );

  assign c_q_u[0] = '0;
  assign c_q_v[0] = '0;

  for (genvar k = 0; k < QB; k++) begin : g_cell
    lpp_div_cell #(.SW(SW), .QB(QB), .BIT(QB - 1 - k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (c_valid[k]),
      .ready_o (c_ready[k]),
      .rem_u_i (c_rem_u[k]),
      .rem_v_i (c_rem_v[k]),
      .w_i     (c_w[k]),
      .q_u_i   (c_q_u[k]),
      .q_v_i   (c_q_v[k]),
      .flags_i (c_flags[k]),
      .valid_o (c_valid[k+1]),
      .ready_i (c_ready[k+1]),
      .rem_u_o (c_rem_u[k+1]),
      .rem_v_o (c_rem_v[k+1]),
      .w_o     (c_w[k+1]),
      .q_u_o   (c_q_u[k+1]),
      .q_v_o   (c_q_v[k+1]),
      .flags_o (c_flags[k+1])
    );
  end

  lpp_out #(.QB(QB), .PB(PIXEL_BITS)) u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (c_valid[QB]),
    .ready_o  (c_ready[QB]),
    .q_u_i    (c_q_u[QB]),
    .q_v_i    (c_q_v[QB]),
    .flags_i  (c_flags[QB]),
    .width_i  (width_q),
    .height_i (height_q),
    .pixel_o  (pixel_out)
  );

endmodule

>>> test/tb_lidar_point_pinhole_projection_unit.sv
// Testbench for the LiDAR pinhole projection unit: randomized points, matrices and stalls.
`timescale 1ns / 1ps

module tb_lidar_point_pinhole_projection_unit;
  import lpp_pkg::*;

  localparam int CB = 24;
  localparam int PB = 16;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [PB-1:0] u;
    logic [PB-1:0] v;
    logic          in_image;
    logic          depth_invalid;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lpp_point_if #(.COORD_BITS(CB)) pt_if ();
  lpp_pixel_if #(.PIXEL_BITS(PB)) px_if ();
  lpp_cfg_if cfg_if ();

  lidar_point_pinhole_projection_unit #(.COORD_BITS(CB), .PIXEL_BITS(PB)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .point_in(pt_if), .pixel_out(px_if), .cfg(cfg_if)
  );

  logic [63:0] matrix_regs [7];
  pixel_t      pending_pixels [$];
  int          errors = 0;
  int          hold_off = 0;
  bit          no_idle = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic longint row_sum(int r, longint x, longint y, longint z);
    logic [63:0] xy;
    logic [63:0] zt;
    xy = matrix_regs[2 * r];
    zt = matrix_regs[2 * r + 1];
    return longint'($signed(xy[31:0])) * x + longint'($signed(xy[63:32])) * y
         + longint'($signed(zt[31:0])) * z + longint'($signed(zt[63:32]));
  endfunction

  function automatic logic [PB-1:0] clamp_pixel(longint q);
    if (q > 32767) return 16'h7fff;
    if (q < -32768) return 16'h8000;
    return q[PB-1:0];
  endfunction

  function automatic pixel_t project_point(logic [CB-1:0] px, logic [CB-1:0] py,
                                           logic [CB-1:0] pz);
    longint a, b, w, qa, qb, wd, ht;
    pixel_t p;
    a = row_sum(0, longint'($signed(px)), longint'($signed(py)), longint'($signed(pz)));
    b = row_sum(1, longint'($signed(px)), longint'($signed(py)), longint'($signed(pz)));
    w = row_sum(2, longint'($signed(px)), longint'($signed(py)), longint'($signed(pz)));
    wd = longint'(matrix_regs[6][15:0]);
    ht = longint'(matrix_regs[6][31:16]);
    p = '0;
    if (w <= 0) begin
      p.depth_invalid = 1'b1;
      return p;
    end
    qa = a / w;
    qb = b / w;
    p.u = clamp_pixel(qa);
    p.v = clamp_pixel(qb);
    p.in_image = (a >= 0) && (qa < wd) && (b >= 0) && (qb < ht);
    return p;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni) begin
      if (px_if.valid && px_if.ready) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = pending_pixels.pop_front();
          if (px_if.pixel_u !== want.u)
            report_mismatch("pixel_u", $signed(px_if.pixel_u), $signed(want.u));
          if (px_if.pixel_v !== want.v)
            report_mismatch("pixel_v", $signed(px_if.pixel_v), $signed(want.v));
          if (px_if.in_image !== want.in_image)
            report_mismatch("in_image", px_if.in_image, want.in_image);
          if (px_if.depth_invalid !== want.depth_invalid)
            report_mismatch("depth_invalid", px_if.depth_invalid, want.depth_invalid);
        end
      end
      if (pt_if.valid && pt_if.ready)
        pending_pixels.push_back(project_point(pt_if.point_x, pt_if.point_y, pt_if.point_z));
      if (cfg_if.valid && cfg_if.ready && cfg_if.index != REG_UNUSED)
        matrix_regs[cfg_if.index] = (cfg_if.index == REG_IMAGE_SIZE) ?
                                    {32'd0, cfg_if.data[31:0]} : cfg_if.data;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  int stall_run = 0;
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off--;
      px_if.ready <= 1'b0;
    end else if (no_idle) begin
      px_if.ready <= 1'b1;
    end else if (stall_run > 0) begin
      stall_run--;
      px_if.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) < 2) stall_run = $urandom_range(10, 40);
      px_if.ready <= ($urandom_range(0, 99) >= 25);
    end
  end

  task automatic send_point(logic [CB-1:0] x, logic [CB-1:0] y, logic [CB-1:0] z);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      pt_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pt_if.valid   <= 1'b1;
    pt_if.point_x <= x;
    pt_if.point_y <= y;
    pt_if.point_z <= z;
    do @(posedge clk_i); while (!pt_if.ready);
  endtask

  task automatic drain();
    @(negedge clk_i);
    pt_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [63:0] pack_pair(int lo, int hi);
    return {hi[31:0], lo[31:0]};
  endfunction

  task automatic load_camera(int fx, int fy, int cx, int cy, int tz, logic [31:0] size);
    write_reg(REG_ROW0_XY, pack_pair(fx << 16, 0));
    write_reg(REG_ROW0_ZT, pack_pair(cx << 16, 0));
    write_reg(REG_ROW1_XY, pack_pair(0, fy << 16));
    write_reg(REG_ROW1_ZT, pack_pair(cy << 16, 0));
    write_reg(REG_ROW2_XY, 64'd0);
    write_reg(REG_ROW2_ZT, pack_pair(1 << 16, tz));
    write_reg(REG_IMAGE_SIZE, {32'd0, size});
  endtask

  task automatic load_random_matrix();
    for (int i = 0; i < 6; i++) write_reg(i[CFG_IDX_BITS-1:0], {$urandom(), $urandom()});
    write_reg(REG_IMAGE_SIZE, {$urandom(), $urandom()});
  endtask

  function automatic logic [CB-1:0] near_coord(int span);
    return CB'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic test_directed();
    load_camera(500, 500, 320, 240, 0, {16'd480, 16'd640});
    write_reg(REG_UNUSED, 64'hffff_ffff_ffff_ffff);
    send_point(24'd0, 24'd0, 24'd1000);
    send_point(24'd100, -24'd50, 24'd2000);
    send_point(24'd0, 24'd0, 24'd0);
    send_point(24'd5, 24'd5, -24'd1000);
    send_point(24'h7fffff, 24'h7fffff, 24'd1);
    send_point(24'h800000, 24'h800000, 24'd1);
    send_point(24'h7fffff, 24'h800000, 24'h7fffff);
    send_point(-24'd640, 24'd0, 24'd1000);
    send_point(24'd639, 24'd479, 24'd1000);
    send_point(24'd1000, 24'd1000, 24'd1000);
    send_point(24'h800000, 24'h7fffff, 24'h800000);
    drain();
    write_reg(REG_IMAGE_SIZE, 64'hffff_ffff_0000_0000);
    send_point(24'd0, 24'd0, 24'd1000);
    drain();
    write_reg(REG_IMAGE_SIZE, 64'h0000_0000_ffff_ffff);
    for (int i = 0; i < 6; i++) write_reg(i[CFG_IDX_BITS-1:0], 64'h8000_0000_8000_0000);
    send_point(24'h7fffff, 24'h7fffff, 24'h7fffff);
    send_point(24'h800000, 24'h800000, 24'h800000);
    send_point(24'd0, 24'd0, 24'd0);
    drain();
    for (int i = 0; i < 6; i++) write_reg(i[CFG_IDX_BITS-1:0], 64'h7fff_ffff_7fff_ffff);
    send_point(24'h800000, 24'h800000, 24'h800000);
    send_point(24'h7fffff, 24'h7fffff, 24'h7fffff);
    send_point(24'd0, 24'd0, 24'd0);
    drain();
  endtask

  task automatic test_random_camera(int count);
    for (int k = 0; k < 5; k++) begin
      load_camera($urandom_range(1, 2000), $urandom_range(1, 2000), $urandom_range(0, 1000),
                  $urandom_range(0, 800), $urandom_range(0, 3) == 0 ? -$urandom_range(0, 5000) : 0,
                  {16'($urandom_range(0, 1000)), 16'($urandom_range(0, 1400))});
      for (int i = 0; i < count; i++) begin
        if ($urandom_range(0, 9) < 8)
          send_point(near_coord(20000), near_coord(20000), CB'($urandom_range(0, 60000)));
        else
          send_point(CB'($urandom()), CB'($urandom()), CB'($urandom()));
      end
      drain();
    end
  endtask

  task automatic test_random_matrix(int count);
    for (int k = 0; k < 4; k++) begin
      load_random_matrix();
      for (int i = 0; i < count; i++)
        send_point(CB'($urandom()), CB'($urandom()), CB'($urandom()));
      drain();
    end
  endtask

  task automatic test_backpressure();
    hold_off = 300;
    for (int i = 0; i < 80; i++)
      send_point(near_coord(9000), near_coord(9000), CB'($urandom_range(1, 30000)));
    drain();
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    for (int i = 0; i < 150; i++)
      send_point(near_coord(9000), near_coord(9000), CB'($urandom_range(0, 30000)));
    drain();
    no_idle = 1'b0;
  endtask

  initial begin
    pt_if.valid = 1'b0;
    pt_if.point_x = '0;
    pt_if.point_y = '0;
    pt_if.point_z = '0;
    px_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    for (int i = 0; i < 7; i++) matrix_regs[i] = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random_camera(200);
    test_random_matrix(100);
    load_camera(700, 700, 640, 360, 0, {16'd720, 16'd1280});
    test_backpressure();
    test_back_to_back();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
